[design/prac_pkg.sv]
// prac_pkg: shared constants and the quarter-wave sine table for the point rotator
`timescale 1ns / 1ps

package prac_pkg;

	// register index codes of the configuration port
	localparam logic [1:0] CFG_ROTATION_ANGLE = 2'd0;
	localparam logic [1:0] CFG_CENTER_X       = 2'd1;
	localparam logic [1:0] CFG_CENTER_Y       = 2'd2;

	// angle format: 256 steps per full turn
	localparam int ANGLE_WIDTH = 8;
	// quarter-wave table entries are Q1.15, 0 to 32768
	localparam int QS_WIDTH    = 17;
	localparam int QS_FRAC     = 15;

	typedef logic [ANGLE_WIDTH-1:0] angle_t;
	typedef logic [QS_WIDTH-1:0]    qsine_t;

	// round(32768 * sin(k * pi / 128)) for k = 0..64
	function automatic qsine_t quarter_sine(input logic [6:0] k);
		qsine_t v;
		case (k)
			7'd0:  v = 17'd0;     7'd1:  v = 17'd804;   7'd2:  v = 17'd1608;
			7'd3:  v = 17'd2411;  7'd4:  v = 17'd3212;  7'd5:  v = 17'd4011;
			7'd6:  v = 17'd4808;  7'd7:  v = 17'd5602;  7'd8:  v = 17'd6393;
			7'd9:  v = 17'd7180;  7'd10: v = 17'd7962;  7'd11: v = 17'd8740;
			7'd12: v = 17'd9512;  7'd13: v = 17'd10279; 7'd14: v = 17'd11039;
			7'd15: v = 17'd11793; 7'd16: v = 17'd12540; 7'd17: v = 17'd13279;
			7'd18: v = 17'd14010; 7'd19: v = 17'd14733; 7'd20: v = 17'd15447;
			7'd21: v = 17'd16151; 7'd22: v = 17'd16846; 7'd23: v = 17'd17531;
			7'd24: v = 17'd18205; 7'd25: v = 17'd18868; 7'd26: v = 17'd19520;
			7'd27: v = 17'd20160; 7'd28: v = 17'd20788; 7'd29: v = 17'd21403;
			7'd30: v = 17'd22006; 7'd31: v = 17'd22595; 7'd32: v = 17'd23170;
			7'd33: v = 17'd23732; 7'd34: v = 17'd24279; 7'd35: v = 17'd24812;
			7'd36: v = 17'd25330; 7'd37: v = 17'd25833; 7'd38: v = 17'd26320;
			7'd39: v = 17'd26791; 7'd40: v = 17'd27246; 7'd41: v = 17'd27684;
			7'd42: v = 17'd28106; 7'd43: v = 17'd28511; 7'd44: v = 17'd28899;
			7'd45: v = 17'd29269; 7'd46: v = 17'd29622; 7'd47: v = 17'd29957;
			7'd48: v = 17'd30274; 7'd49: v = 17'd30572; 7'd50: v = 17'd30853;
			7'd51: v = 17'd31114; 7'd52: v = 17'd31357; 7'd53: v = 17'd31581;
			7'd54: v = 17'd31786; 7'd55: v = 17'd31972; 7'd56: v = 17'd32138;
			7'd57: v = 17'd32286; 7'd58: v = 17'd32413; 7'd59: v = 17'd32522;
			7'd60: v = 17'd32610; 7'd61: v = 17'd32679; 7'd62: v = 17'd32729;
			7'd63: v = 17'd32758; 7'd64: v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage

[design/prac_sincos.sv]
// prac_sincos: sine and cosine of an 8-bit angle in signed fixed point
`timescale 1ns / 1ps

module prac_sincos #(
	parameter int FRAC_BITS = 15
) (
	input  prac_pkg::angle_t               angle,
	output logic signed [FRAC_BITS+1:0]    sin_val,
	output logic signed [FRAC_BITS+1:0]    cos_val
);
	import prac_pkg::*;

	localparam int TW = FRAC_BITS + 2;
	localparam int UP = (FRAC_BITS >= QS_FRAC) ? (FRAC_BITS - QS_FRAC) : 0;
	localparam int DN = (FRAC_BITS <  QS_FRAC) ? (QS_FRAC - FRAC_BITS) : 1;

	angle_t cos_angle;

	// bring a Q1.15 entry to FRAC_BITS, rounding half up when narrowing
	function automatic logic [TW-1:0] scale_entry(input qsine_t raw);
		qsine_t rnd;
		logic [TW-1:0] res;
		rnd = raw + QS_WIDTH'(1 << (DN - 1));
		if (FRAC_BITS >= QS_FRAC) begin
			res = TW'(raw) << UP;
		end else begin
			res = TW'(rnd >> DN);
		end
		return res;
	endfunction

	// quadrant fold: mirror odd quadrants, negate the lower half turn
	function automatic logic signed [TW-1:0] sine_of(input angle_t a);
		logic [6:0] k;
		logic [TW-1:0] mag;
		k   = a[6] ? (7'd64 - {1'b0, a[5:0]}) : {1'b0, a[5:0]};
		mag = scale_entry(quarter_sine(k));
		return a[7] ? -signed'(mag) : signed'(mag);
	endfunction

	assign cos_angle = angle + angle_t'(64);
	assign sin_val   = sine_of(angle);
	assign cos_val   = sine_of(cos_angle);

endmodule

[design/point_rotate_about_center_unit.sv]
// point_rotate_about_center_unit: five-stage pipelined rotation of a point about a center
//
//  channel  | direction | handshake        | contents
//  s_axis   | in        | s_tvalid/tready  | point_x, point_y in s_tdata
//  m_axis   | out       | m_tvalid/tready  | rotated_x, rotated_y in m_tdata, saturated in m_tuser
//  cfg      | in        | cfg_we           | rotation_angle, center_x, center_y
//
// one item is accepted per cycle unless every stage is full and the output stalls
// stages: offset and sine/cosine lookup, four products, sums, truncation, clamp
// arst_n clears all valid bits and the configuration registers to zero
// each stage holds its item while the next one is full and blocked, so bubbles close up
// and a stalled output never blocks input while an earlier stage is empty
`timescale 1ns / 1ps

module point_rotate_about_center_unit #(
	parameter int COORD_WIDTH    = 24,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	// configuration write port
	input  logic                                         cfg_we,
	input  logic [1:0]                                   cfg_index,
	input  logic [COORD_WIDTH-1:0]                       cfg_wdata,
	// input items
	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// s_tdata: point_x, point_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]           s_tdata,
	// result items
	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// m_tdata: rotated_x, rotated_y, zero fill
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]           m_tdata,
	// m_tuser: saturated
	output logic                                         m_tuser
);
	import prac_pkg::*;

	localparam int CW  = COORD_WIDTH;
	localparam int F   = TRIG_FRAC_BITS;
	localparam int BW  = ((2*COORD_WIDTH+7)/8)*8;
	localparam int DW  = CW + 1;
	localparam int TW  = F + 2;
	localparam int AW  = DW + TW;
	localparam int QW  = AW - F;

	localparam logic signed [QW-1:0] COORD_HI = QW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [QW-1:0] COORD_LO = -COORD_HI - QW'(1);

	// configuration registers
	angle_t                  rotation_angle_q;
	logic signed [CW-1:0]    center_x_q;
	logic signed [CW-1:0]    center_y_q;

	// pipeline valid bits and stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	// stage payloads
	logic signed [DW-1:0]    dx_s1, dy_s1;
	logic signed [TW-1:0]    sin_s1, cos_s1;
	logic signed [AW-1:0]    xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [AW-1:0]    accx_s3, accy_s3;
	logic signed [QW-1:0]    tx_s4, ty_s4;
	logic signed [CW-1:0]    rx_s5, ry_s5;
	logic                    sat_s5;

	// combinational helpers
	logic signed [CW-1:0]    point_x, point_y;
	logic signed [TW-1:0]    sin_val, cos_val;
	logic signed [AW-1:0]    biasx, biasy, tbx, tby;
	logic signed [CW-1:0]    clx, cly;
	logic                    satx, saty;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_angle_q <= '0;
			center_x_q       <= '0;
			center_y_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROTATION_ANGLE: rotation_angle_q <= cfg_wdata[ANGLE_WIDTH-1:0];
				CFG_CENTER_X:       center_x_q       <= cfg_wdata;
				CFG_CENTER_Y:       center_y_q       <= cfg_wdata;
				default:            ;
			endcase
		end
	end

	// a stage loads when it is empty or its successor takes its item
	assign en_s5    = !v_s5 || m_tready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: offsets from the center and trig lookup
	assign point_x = s_tdata[CW-1:0];
	assign point_y = s_tdata[2*CW-1:CW];

	prac_sincos #(
		.FRAC_BITS (F)
	) u_sincos (
		.angle   (rotation_angle_q),
		.sin_val (sin_val),
		.cos_val (cos_val)
	);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			dx_s1  <= DW'(point_x) - DW'(center_x_q);
			dy_s1  <= DW'(point_y) - DW'(center_y_q);
			sin_s1 <= sin_val;
			cos_s1 <= cos_val;
		end
	end

	// stage 2: the four products
	always_ff @(posedge clk) begin
		if (en_s2) begin
			xc_s2 <= AW'(dx_s1) * AW'(cos_s1);
			ys_s2 <= AW'(dy_s1) * AW'(sin_s1);
			xs_s2 <= AW'(dx_s1) * AW'(sin_s1);
			yc_s2 <= AW'(dy_s1) * AW'(cos_s1);
		end
	end

	// stage 3: scaled center plus rotated offset
	always_ff @(posedge clk) begin
		if (en_s3) begin
			accx_s3 <= (AW'(center_x_q) <<< F) + xc_s2 - ys_s2;
			accy_s3 <= (AW'(center_y_q) <<< F) + xs_s2 + yc_s2;
		end
	end

	// stage 4: drop fraction bits, rounding toward zero
	assign biasx = accx_s3[AW-1] ? AW'((64'sd1 <<< F) - 64'sd1) : '0;
	assign biasy = accy_s3[AW-1] ? AW'((64'sd1 <<< F) - 64'sd1) : '0;
	assign tbx   = (accx_s3 + biasx) >>> F;
	assign tby   = (accy_s3 + biasy) >>> F;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			tx_s4 <= tbx[QW-1:0];
			ty_s4 <= tby[QW-1:0];
		end
	end

	// stage 5: clamp to the coordinate range
	always_comb begin
		satx = 1'b0;
		saty = 1'b0;
		clx  = tx_s4[CW-1:0];
		cly  = ty_s4[CW-1:0];
		if (tx_s4 > COORD_HI) begin
			clx  = COORD_HI[CW-1:0];
			satx = 1'b1;
		end else if (tx_s4 < COORD_LO) begin
			clx  = COORD_LO[CW-1:0];
			satx = 1'b1;
		end
		if (ty_s4 > COORD_HI) begin
			cly  = COORD_HI[CW-1:0];
			saty = 1'b1;
		end else if (ty_s4 < COORD_LO) begin
			cly  = COORD_LO[CW-1:0];
			saty = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rx_s5  <= clx;
			ry_s5  <= cly;
			sat_s5 <= satx || saty;
		end
	end

	// result channel
	assign m_tvalid = v_s5;
	assign m_tdata  = BW'({ry_s5, rx_s5});
	assign m_tuser  = sat_s5;

	// a flagged result sits on a range limit
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && sat_s5) |-> (rx_s5 == COORD_HI[CW-1:0] || rx_s5 == COORD_LO[CW-1:0] ||
			ry_s5 == COORD_HI[CW-1:0] || ry_s5 == COORD_LO[CW-1:0]))
		else $error("saturated result not at a range limit");

	// stage 4, when blocked by its successor, keeps its item
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en_s4) |=> (v_s4 && $stable(tx_s4) && $stable(ty_s4)))
		else $error("stage 4 item changed while stalled");

	// input is refused only when every stage is full and the output stalls
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !(v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_tready))
		else $error("input taken into a full pipeline");

	a_ready_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input refused while a stage is empty");

endmodule

[bench/tb_point_rotate_about_center_unit.sv]
// testbench for point_rotate_about_center_unit: directed table and random points
`timescale 1ns / 1ps

module tb_point_rotate_about_center_unit;
	import prac_pkg::*;

	localparam int COORD_W       = 24;
	localparam int FRAC_W        = 15;
	localparam int DATA_W        = ((2*COORD_W+7)/8)*8;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 10;
	localparam int NUM_PHASES    = 12;
	localparam int PHASE_ITEMS   = 170;
	localparam int REPORT_MAX    = 10;

	// index past the register list, writes there must be dropped
	localparam logic [1:0] CFG_SPARE = 2'd3;

	// angles with exact swap and negate handling
	localparam angle_t NO_TURN            = 8'd0;
	localparam angle_t QUARTER_TURN       = 8'd64;
	localparam angle_t HALF_TURN          = 8'd128;
	localparam angle_t THREE_QUARTER_TURN = 8'd192;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = 24'h7FFFFF;
	localparam coord_t COORD_MIN = 24'h800000;

	typedef struct packed {
		logic   sat;
		coord_t y;
		coord_t x;
	} rot_result_t;

	typedef struct {
		angle_t      turn;
		coord_t      cx;
		coord_t      cy;
		coord_t      px;
		coord_t      py;
		bit          typed;
		rot_result_t want;
	} point_case_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              cfg_we    = 1'b0;
	logic [1:0]        cfg_index = '0;
	logic [COORD_W-1:0] cfg_wdata = '0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata   = '0;
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tuser;

	// mirror of the configuration registers
	angle_t turn_cfg     = '0;
	coord_t center_x_cfg = '0;
	coord_t center_y_cfg = '0;

	bit          idle_on        = 1'b1;
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	int          ready_hold     = 0;
	rot_result_t head_due;
	rot_result_t rotations_due[$];
	point_case_t directed_cases[$];

	// round(32768 * sin(k * pi / 128)), k = 0..64
	int sine_q15 [0:64] = '{
		0, 804, 1608, 2411, 3212, 4011, 4808, 5602,
		6393, 7180, 7962, 8740, 9512, 10279, 11039, 11793,
		12540, 13279, 14010, 14733, 15447, 16151, 16846, 17531,
		18205, 18868, 19520, 20160, 20788, 21403, 22006, 22595,
		23170, 23732, 24279, 24812, 25330, 25833, 26320, 26791,
		27246, 27684, 28106, 28511, 28899, 29269, 29622, 29957,
		30274, 30572, 30853, 31114, 31357, 31581, 31786, 31972,
		32138, 32286, 32413, 32522, 32610, 32679, 32729, 32758,
		32768
	};

	point_rotate_about_center_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// sine by quadrant: mirror on odd quadrants, negate in the lower half turn
	function automatic longint sine_step(angle_t a);
		longint v;
		v = longint'(a[6] ? sine_q15[64 - a[5:0]] : sine_q15[a[5:0]]);
		return a[7] ? -v : v;
	endfunction

	// divide by 2^FRAC_W rounding toward zero
	function automatic longint drop_fraction(longint acc);
		return (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
	endfunction

	function automatic coord_t clamp_coord(longint v, inout logic hit);
		if (v > COORD_MAX) begin
			hit = 1'b1;
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			hit = 1'b1;
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	// expected rotation of one point under the current configuration
	function automatic rot_result_t rotate_point(coord_t px, coord_t py);
		longint      cx, cy, dx, dy, nx, ny, sn, cs;
		logic        hit;
		rot_result_t r;
		cx = longint'(center_x_cfg);
		cy = longint'(center_y_cfg);
		dx = longint'(px) - cx;
		dy = longint'(py) - cy;
		case (turn_cfg)
			NO_TURN: begin
				nx = longint'(px);
				ny = longint'(py);
			end
			QUARTER_TURN: begin
				nx = cx - dy;
				ny = cy + dx;
			end
			HALF_TURN: begin
				nx = cx - dx;
				ny = cy - dy;
			end
			THREE_QUARTER_TURN: begin
				nx = cx + dy;
				ny = cy - dx;
			end
			default: begin
				sn = sine_step(turn_cfg);
				cs = sine_step(angle_t'(turn_cfg + QUARTER_TURN));
				nx = drop_fraction((cx <<< FRAC_W) + dx * cs - dy * sn);
				ny = drop_fraction((cy <<< FRAC_W) + dx * sn + dy * cs);
			end
		endcase
		hit = 1'b0;
		r.x = clamp_coord(nx, hit);
		r.y = clamp_coord(ny, hit);
		r.sat = hit;
		return r;
	endfunction

	// random coordinate: full range, near a given spot, extremes, zero or minus one, or small
	function automatic coord_t pick_coord(coord_t near);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return coord_t'($urandom);
			4, 5, 6: return near + coord_t'($urandom_range(0, 2000)) - coord_t'(1000);
			7, 8: begin
				case ($urandom_range(0, 3))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return coord_t'($urandom_range(0, 510)) - coord_t'(255);
		endcase
	endfunction

	task automatic add_case(angle_t turn, coord_t cx, coord_t cy, coord_t px, coord_t py,
			bit typed, coord_t wx, coord_t wy, logic wsat);
		point_case_t row;
		row.turn = turn;
		row.cx = cx;
		row.cy = cy;
		row.px = px;
		row.py = py;
		row.typed = typed;
		row.want.x = wx;
		row.want.y = wy;
		row.want.sat = wsat;
		directed_cases.push_back(row);
	endtask

	task automatic report_mismatch(string what, logic [COORD_W-1:0] want,
			logic [COORD_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t: mismatch on %s: expected %0d, got %0d",
				$time, what, $signed(want), $signed(got));
	endtask

	// stop feeding and wait until every expected result has left the pipeline
	task automatic drain_pipeline();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (rotations_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write all registers while idle, plus a dropped write past the list
	task automatic load_config(angle_t turn, coord_t cx, coord_t cy);
		drain_pipeline();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROTATION_ANGLE;
		cfg_wdata <= {16'($urandom), turn};
		@(posedge clk);
		cfg_index <= CFG_CENTER_X;
		cfg_wdata <= cx;
		@(posedge clk);
		cfg_index <= CFG_CENTER_Y;
		cfg_wdata <= cy;
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_wdata <= COORD_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		turn_cfg = turn;
		center_x_cfg = cx;
		center_y_cfg = cy;
	endtask

	// offer one point, optionally after an input gap, and log its expected result
	task automatic send_point(coord_t px, coord_t py, bit typed, rot_result_t want);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do @(posedge clk); while (!s_tready);
		rotations_due.push_back(typed ? want : rotate_point(px, py));
	endtask

	// output stalls come in bursts of random length, only while idling is on
	always @(posedge clk) begin
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 6);
		end else
			m_tready <= 1'b1;
	end

	// result check and stall watchdog
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (rotations_due.size() == 0)
				report_mismatch("item with nothing expected", '0, m_tdata[COORD_W-1:0]);
			else begin
				head_due = rotations_due.pop_front();
				if (m_tdata[COORD_W-1:0] !== head_due.x)
					report_mismatch("rotated_x", head_due.x, m_tdata[COORD_W-1:0]);
				if (m_tdata[2*COORD_W-1:COORD_W] !== head_due.y)
					report_mismatch("rotated_y", head_due.y, m_tdata[2*COORD_W-1:COORD_W]);
				if (m_tuser !== head_due.sat)
					report_mismatch("saturated", COORD_W'(head_due.sat), COORD_W'(m_tuser));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else if (++quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		point_case_t row;
		angle_t      turn;

		// reset configuration, angle zero passes the point through
		add_case(NO_TURN, 0, 0, COORD_MAX, COORD_MIN, 1, COORD_MAX, COORD_MIN, 0);
		add_case(NO_TURN, 0, 0, -1, 0, 1, -1, 0, 0);
		add_case(NO_TURN, 5, 7, 100, 200, 1, 100, 200, 0);
		// quarter, half and three-quarter turns, with saturation at the extremes
		add_case(QUARTER_TURN, 0, 0, 3, 5, 1, -5, 3, 0);
		add_case(QUARTER_TURN, 0, 0, COORD_MIN, 0, 1, 0, COORD_MIN, 0);
		add_case(QUARTER_TURN, 0, 0, 0, COORD_MIN, 1, COORD_MAX, 0, 1);
		add_case(QUARTER_TURN, 100, -50, 110, -40, 1, 90, -40, 0);
		add_case(HALF_TURN, 0, 0, 10, -20, 1, -10, 20, 0);
		add_case(HALF_TURN, 0, 0, COORD_MIN, COORD_MIN, 1, COORD_MAX, COORD_MAX, 1);
		add_case(THREE_QUARTER_TURN, 0, 0, 3, 5, 1, 5, -3, 0);
		add_case(THREE_QUARTER_TURN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			1, COORD_MAX, COORD_MAX, 1);
		// table path with the point on the center gives the center back
		add_case(8'd32, 1000, -1000, 1000, -1000, 1, 1000, -1000, 0);
		add_case(8'd200, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			1, COORD_MIN, COORD_MIN, 0);
		add_case(8'd1, 0, 0, 0, 0, 1, 0, 0, 0);
		// table path, predicted
		add_case(8'd1, 0, 0, COORD_MAX, COORD_MAX, 0, 0, 0, 0);
		add_case(8'd255, 0, 0, COORD_MIN, COORD_MIN, 0, 0, 0, 0);
		add_case(8'd127, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 0, 0);
		add_case(8'd96, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 0, 0, 0, 0);
		add_case(8'd160, 0, 0, 12345, -6789, 0, 0, 0, 0);
		add_case(8'd224, 0, 0, -1, -1, 0, 0, 0, 0);
		add_case(8'd65, 0, 0, 1, 0, 0, 0, 0, 0);
		add_case(8'd32, 0, 0, 1, 0, 0, 0, 0, 0);
		add_case(8'd32, 0, 0, -1, 0, 0, 0, 0, 0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_cases[k]) begin
			row = directed_cases[k];
			if (row.turn != turn_cfg || row.cx != center_x_cfg || row.cy != center_y_cfg)
				load_config(row.turn, row.cx, row.cy);
			send_point(row.px, row.py, row.typed, row.want);
		end

		// random phases, each with its own setting; the last two and every fourth run without idling
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if ($urandom_range(0, 2) == 0)
				turn = angle_t'(QUARTER_TURN * $urandom_range(0, 3));
			else
				turn = angle_t'($urandom);
			idle_on = (phase < NUM_PHASES - 2) && (phase % 4 != 3);
			load_config(turn, pick_coord('0), pick_coord('0));
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_point(pick_coord(center_x_cfg), pick_coord(center_y_cfg), 1'b0, '0);
		end

		drain_pipeline();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
